// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge.
`define CHK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("%m: check failed");

// Check a property, skipped while reset is high.
`define CHK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

`endif

// ===== hdl/dspbm_pkg.sv =====
package dspbm_pkg;

   localparam int NUM_BINS     = 1440;
   localparam int COORD_BITS   = 16;
   localparam int BIN_BITS     = 11;
   localparam int RANGE_BITS   = 16;
   localparam int ROT_Q15      = 23170;
   localparam int CORDIC_STEPS = 20;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] CSR_OFFSET_X        = 2'd0;
   localparam logic [1:0] CSR_OFFSET_Y        = 2'd1;
   localparam logic [1:0] CSR_EDGE_SKIP       = 2'd2;
   localparam logic [1:0] CSR_POINTS_PER_SCAN = 2'd3;

   typedef struct packed {
      logic                         op;
      logic                         sensor;
      logic signed [COORD_BITS-1:0] x_pos;
      logic signed [COORD_BITS-1:0] y_pos;
      logic [BIN_BITS-1:0]          drain_bin;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic [7:0]         edge_skip;
      logic [11:0]        points_per_scan;
   } cfg_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      begin
         unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            default: v = 32'd0;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== hdl/dual_scan_polar_bin_max_merge.sv =====
// A drain reads its bin and loads the result register; a point (square root and CORDIC side
// by side, normalize before 20 CORDIC steps, no CORDIC at the origin) is binned and written.
// The back end takes one item at a time: the queue is popped only in idle, and a drain
// waits in its update state while the held result is stalled.
// Reset: a pass over the 1440 bins clears memory with req_stall high; configuration resets.
module dual_scan_polar_bin_max_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic                req_sensor,
   input  logic [11:0]         req_point_index,
   input  logic signed [15:0]  req_x_pos,
   input  logic signed [15:0]  req_y_pos,
   input  logic [10:0]         req_drain_bin,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [10:0]         rsp_out_bin,
   output logic [15:0]         rsp_max_range,
   output logic                rsp_bin_hit,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   dspbm_pkg::cfg_type  cfg_ff;
   dspbm_pkg::item_type push_item;
   dspbm_pkg::head_type head;
   logic                push;
   logic                queue_full;
   logic                pop;
   logic                clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x        <= 16'sd200;
         cfg_ff.offset_y        <= 16'sd47;
         cfg_ff.edge_skip       <= 8'd80;
         cfg_ff.points_per_scan <= 12'd720;
      end else if (csr_write) begin
         unique case (csr_index)
            dspbm_pkg::CSR_OFFSET_X:        cfg_ff.offset_x        <= csr_data;
            dspbm_pkg::CSR_OFFSET_Y:        cfg_ff.offset_y        <= csr_data;
            dspbm_pkg::CSR_EDGE_SKIP:       cfg_ff.edge_skip       <= csr_data[7:0];
            dspbm_pkg::CSR_POINTS_PER_SCAN: cfg_ff.points_per_scan <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   dspbm_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_sensor      (req_sensor),
      .req_point_index (req_point_index),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_drain_bin   (req_drain_bin),
      .cfg             (cfg_ff),
      .clearing        (clearing),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   dspbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   dspbm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .cfg           (cfg_ff),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_bin   (rsp_out_bin),
      .rsp_max_range (rsp_max_range),
      .rsp_bin_hit   (rsp_bin_hit)
   );

endmodule

// ===== hdl/dspbm_queue.sv =====
module dspbm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dspbm_pkg::item_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output dspbm_pkg::head_type  head
);

   dspbm_pkg::item_type                  slot_ff [dspbm_pkg::QUEUE_DEPTH];
   logic [dspbm_pkg::QPTR_BITS-1:0]      wr_ptr_ff;
   logic [dspbm_pkg::QPTR_BITS-1:0]      rd_ptr_ff;
   logic [dspbm_pkg::QPTR_BITS:0]        count_ff;
   logic                                 do_pop;

   assign full       = (count_ff == (dspbm_pkg::QPTR_BITS+1)'(dspbm_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ===== hdl/dspbm_front.sv =====
module dspbm_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic                 req_sensor,
   input  logic [11:0]          req_point_index,
   input  logic signed [15:0]   req_x_pos,
   input  logic signed [15:0]   req_y_pos,
   input  logic [10:0]          req_drain_bin,
   input  dspbm_pkg::cfg_type   cfg,
   input  logic                 clearing,
   input  logic                 queue_full,
   output logic                 push,
   output dspbm_pkg::item_type  push_item
);

   logic        accept;
   logic        keep;
   logic [12:0] idx_end;

   assign req_stall = queue_full || clearing;
   assign accept    = req_valid && !req_stall;
   assign idx_end   = {1'b0, req_point_index} + 13'(cfg.edge_skip);

   // drop points too close to either end of the scan
   assign keep = (req_op == dspbm_pkg::OP_DRAIN) ||
                 ((req_point_index >= 12'(cfg.edge_skip)) &&
                  (idx_end < {1'b0, cfg.points_per_scan}));

   assign push = accept && keep;

   assign push_item.op        = req_op;
   assign push_item.sensor    = req_sensor;
   assign push_item.x_pos     = req_x_pos;
   assign push_item.y_pos     = req_y_pos;
   assign push_item.drain_bin = req_drain_bin;

endmodule

// ===== hdl/dspbm_back.sv =====
module dspbm_back (
   input  logic                clock,
   input  logic                reset,
   input  dspbm_pkg::head_type head,
   output logic                pop,
   input  dspbm_pkg::cfg_type  cfg,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [10:0]         rsp_out_bin,
   output logic [15:0]         rsp_max_range,
   output logic                rsp_bin_hit
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ROT, S_OFS, S_XY, S_SQ, S_SUM, S_RUN, S_BIN, S_RD, S_UPD
   } state_type;

   typedef enum logic [1:0] {A_NORM, A_CORD, A_DONE} aphase_type;

   localparam logic signed [33:0] Z_MAX  = 34'sd1073741824;
   localparam logic [23:0]        NORM_T = 24'h800000;

   function automatic logic signed [27:0] asr(input logic signed [27:0] v,
                                              input logic [4:0] s);
      logic signed [27:0] m;
      begin
         m = (v < 0) ? -v : v;
         m = m >>> s;
         return (v < 0) ? -m : m;
      end
   endfunction

   state_type               state_ff;
   aphase_type              aph_ff;
   logic [10:0]             clr_ff;

   logic [16:0]             mem [dspbm_pkg::NUM_BINS];
   logic [16:0]             rd_data_ff;
   logic [10:0]             addr_ff;
   logic                    mem_we;
   logic [10:0]             mem_wa;
   logic [16:0]             mem_wd;

   logic                    op_ff;
   logic                    sensor_ff;
   logic                    in_range_ff;
   logic signed [32:0]      pd_ff, ps_ff;
   logic signed [17:0]      rx_ff, ry_ff;
   logic signed [18:0]      bx_ff, by_ff;
   logic                    xneg_ff, yneg_ff;
   logic [35:0]             sqx_ff, sqy_ff;
   logic [35:0]             rad_ff;
   logic [20:0]             rem_ff;
   logic [17:0]             root_ff;
   logic [4:0]              sq_cnt_ff;
   logic [23:0]             nx_ff, ny_ff;
   logic signed [27:0]      cx_ff, cy_ff;
   logic signed [33:0]      z_ff;
   logic [4:0]              ci_ff;
   logic [15:0]             range_ff;

   logic                    rsp_valid_ff;
   logic [10:0]             rsp_bin_ff;
   logic [15:0]             rsp_max_ff;
   logic                    rsp_hit_ff;

   // combinational helpers
   logic signed [16:0]      dif, sum;
   logic [32:0]             mag_d, mag_s;
   logic [17:0]             q_d, q_s;
   logic [17:0]             ax, ay;
   logic [20:0]             rem_sh, trial;
   logic signed [27:0]      sx, sy;
   logic [31:0]             aq, ang;
   logic [42:0]             bprod;
   logic [10:0]             bin_calc;
   logic                    rsp_free;
   logic                    rsp_load;
   logic                    sq_done;

   assign clearing = (state_ff == S_CLEAR);
   assign pop      = (state_ff == S_IDLE) && head.valid;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == S_UPD) && (op_ff == dspbm_pkg::OP_DRAIN) && rsp_free;
   assign sq_done  = (sq_cnt_ff == 5'd18);

   assign dif   = 17'(head.item.x_pos) - 17'(head.item.y_pos);
   assign sum   = 17'(head.item.x_pos) + 17'(head.item.y_pos);
   assign mag_d = pd_ff[32] ? 33'(-pd_ff) : 33'(pd_ff);
   assign mag_s = ps_ff[32] ? 33'(-ps_ff) : 33'(ps_ff);
   assign q_d   = 18'((mag_d + 33'd16384) >> 15);
   assign q_s   = 18'((mag_s + 33'd16384) >> 15);
   assign ax    = bx_ff[18] ? 18'(-bx_ff) : 18'(bx_ff);
   assign ay    = by_ff[18] ? 18'(-by_ff) : 18'(by_ff);

   assign rem_sh = {rem_ff[18:0], rad_ff[35:34]};
   assign trial  = {1'b0, root_ff, 2'b01};

   assign sx = asr(cy_ff, ci_ff);
   assign sy = asr(cx_ff, ci_ff);

   always_comb begin
      if (z_ff < 0) aq = 32'd0;
      else if (z_ff > Z_MAX) aq = 32'(Z_MAX);
      else aq = z_ff[31:0];
      priority if (!xneg_ff && !yneg_ff) ang = aq;
      else if (xneg_ff && !yneg_ff) ang = 32'h80000000 - aq;
      else if (xneg_ff) ang = 32'h80000000 + aq;
      else ang = 32'd0 - aq;
      bprod    = 43'(ang) * 43'(dspbm_pkg::NUM_BINS);
      bin_calc = (bprod[42:32] >= 11'(dspbm_pkg::NUM_BINS)) ?
                 11'(dspbm_pkg::NUM_BINS - 1) : bprod[42:32];
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = 17'd0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
         end
         S_UPD: begin
            if (op_ff == dspbm_pkg::OP_DRAIN) begin
               mem_we = in_range_ff && rsp_free;
            end else begin
               mem_we = 1'b1;
               if (!rd_data_ff[16] || (range_ff > rd_data_ff[15:0])) begin
                  mem_wd = {1'b1, range_ff};
               end else begin
                  mem_wd = rd_data_ff;
               end
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         aph_ff       <= A_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == 11'(dspbm_pkg::NUM_BINS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (head.valid) begin
                  op_ff       <= head.item.op;
                  sensor_ff   <= head.item.sensor;
                  addr_ff     <= head.item.drain_bin;
                  in_range_ff <= (head.item.drain_bin < 11'(dspbm_pkg::NUM_BINS));
                  pd_ff       <= 33'(dif) * 33'(dspbm_pkg::ROT_Q15);
                  ps_ff       <= 33'(sum) * 33'(dspbm_pkg::ROT_Q15);
                  if (head.item.op == dspbm_pkg::OP_DRAIN) state_ff <= S_RD;
                  else state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               // round half away from zero
               rx_ff    <= pd_ff[32] ? -$signed(q_d) : $signed(q_d);
               ry_ff    <= ps_ff[32] ? -$signed(q_s) : $signed(q_s);
               state_ff <= S_OFS;
            end
            S_OFS: begin
               bx_ff    <= sensor_ff ? -(19'(rx_ff) + 19'(cfg.offset_x))
                                     :  (19'(rx_ff) + 19'(cfg.offset_x));
               by_ff    <= sensor_ff ? -(19'(ry_ff) + 19'(cfg.offset_y))
                                     :  (19'(ry_ff) + 19'(cfg.offset_y));
               state_ff <= S_XY;
            end
            S_XY: begin
               sqx_ff   <= 36'(ax) * 36'(ax);
               sqy_ff   <= 36'(ay) * 36'(ay);
               nx_ff    <= 24'(ax);
               ny_ff    <= 24'(ay);
               xneg_ff  <= bx_ff[18];
               yneg_ff  <= by_ff[18];
               z_ff     <= '0;
               aph_ff   <= ((ax == '0) && (ay == '0)) ? A_DONE : A_NORM;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               rad_ff    <= sqx_ff + sqy_ff;
               rem_ff    <= '0;
               root_ff   <= '0;
               sq_cnt_ff <= '0;
               state_ff  <= S_SUM;
            end
            S_SUM: begin
               state_ff <= S_RUN;
            end
            S_RUN: begin
               // square root, two radicand bits a cycle
               if (!sq_done) begin
                  rad_ff    <= {rad_ff[33:0], 2'b00};
                  sq_cnt_ff <= sq_cnt_ff + 1'b1;
                  if (rem_sh >= trial) begin
                     rem_ff  <= rem_sh - trial;
                     root_ff <= {root_ff[16:0], 1'b1};
                  end else begin
                     rem_ff  <= rem_sh;
                     root_ff <= {root_ff[16:0], 1'b0};
                  end
               end
               unique case (aph_ff)
                  A_NORM: begin
                     if (nx_ff < NORM_T && ny_ff < NORM_T) begin
                        nx_ff <= {nx_ff[22:0], 1'b0};
                        ny_ff <= {ny_ff[22:0], 1'b0};
                     end else begin
                        cx_ff  <= 28'(nx_ff);
                        cy_ff  <= 28'(ny_ff);
                        ci_ff  <= '0;
                        aph_ff <= A_CORD;
                     end
                  end
                  A_CORD: begin
                     if (cy_ff >= 0) begin
                        cx_ff <= cx_ff + sx;
                        cy_ff <= cy_ff - sy;
                        z_ff  <= z_ff + 34'(dspbm_pkg::atan_turn(ci_ff));
                     end else begin
                        cx_ff <= cx_ff - sx;
                        cy_ff <= cy_ff + sy;
                        z_ff  <= z_ff - 34'(dspbm_pkg::atan_turn(ci_ff));
                     end
                     ci_ff <= ci_ff + 1'b1;
                     if (ci_ff == 5'(dspbm_pkg::CORDIC_STEPS - 1)) aph_ff <= A_DONE;
                  end
                  default: aph_ff <= A_DONE;
               endcase
               if (sq_done && aph_ff == A_DONE) state_ff <= S_BIN;
            end
            S_BIN: begin
               range_ff <= (root_ff > 18'd65535) ? 16'hFFFF : root_ff[15:0];
               addr_ff  <= bin_calc;
               state_ff <= S_RD;
            end
            S_RD: begin
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (op_ff == dspbm_pkg::OP_DRAIN) begin
                  if (rsp_free) begin
                     rsp_bin_ff   <= addr_ff;
                     rsp_hit_ff   <= in_range_ff && rd_data_ff[16];
                     rsp_max_ff   <= (in_range_ff && rd_data_ff[16]) ? rd_data_ff[15:0]
                                                                     : 16'd0;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_bin   = rsp_bin_ff;
   assign rsp_max_range = rsp_max_ff;
   assign rsp_bin_hit   = rsp_hit_ff;

endmodule

// ===== hdl/dspbm_checker.sv =====
`include "assert_macros.svh"

module dspbm_props (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [10:0] rsp_out_bin,
   input logic [15:0] rsp_max_range,
   input logic        rsp_bin_hit
);

   logic rsp_wait;
   logic rsp_oob;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_oob  = rsp_valid && (rsp_out_bin >= 11'(dspbm_pkg::NUM_BINS));

   `CHK_ALWAYS(a_rst_no_rsp, clock, reset |=> !rsp_valid)
   `CHK_RST(a_clear_stall, clock, reset, $past(reset) |-> req_stall)
   `CHK_RST(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_out_bin))
   `CHK_RST(a_empty_zero, clock, reset, rsp_valid && !rsp_bin_hit |-> rsp_max_range == 16'd0)
   `CHK_RST(a_oob_miss, clock, reset, rsp_oob |-> !rsp_bin_hit)

endmodule

bind dual_scan_polar_bin_max_merge dspbm_props u_checker (.*);
